[hw/rtl/rle_mono_bitmap_expander_core_assert.svh]
// assertion macros for the run-length bitmap expander
// used by the checker file; expects clk and arst_n in scope
`ifndef RLE_MONO_BITMAP_EXPANDER_CORE_ASSERT_SVH
`define RLE_MONO_BITMAP_EXPANDER_CORE_ASSERT_SVH

// clocked assertion, idle while reset is held
`define RMBE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked assertion that also holds across reset
`define RMBE_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/rmbe_pkg.sv]
// shared constants for the run-length bitmap expander
// no dependencies
`default_nettype none

package rmbe_pkg;

	// field widths
	localparam int unsigned ColorW  = 16;
	localparam int unsigned DimW    = 10;
	localparam int unsigned TotalW  = 2 * DimW;
	localparam int unsigned CountW  = 21;
	localparam int unsigned ByteW   = 8;
	localparam int unsigned ReqW    = 2;
	localparam int unsigned CfgIdxW = 2;
	localparam int unsigned PhaseW  = 2;
	localparam int unsigned LaneN   = 4;
	localparam int unsigned GroupW  = LaneN * ColorW;

	// request codes
	localparam logic [ReqW-1:0] REQ_START = 2'd0;
	localparam logic [ReqW-1:0] REQ_BYTE  = 2'd1;
	localparam logic [ReqW-1:0] REQ_FETCH = 2'd2;

	// configuration register indexes
	localparam logic [CfgIdxW-1:0] CFG_FG_COLOR = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_BG_COLOR = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_WIDTH    = 2'd2;
	localparam logic [CfgIdxW-1:0] CFG_HEIGHT   = 2'd3;

	// parser phases
	localparam logic [PhaseW-1:0] PH_CODE    = 2'd0;
	localparam logic [PhaseW-1:0] PH_PATTERN = 2'd1;
	localparam logic [PhaseW-1:0] PH_COUNT   = 2'd2;

	// stream constants
	localparam logic [ByteW-1:0]  ESC_CODE     = 8'h76;
	localparam logic [ColorW-1:0] FG_RESET     = 16'hFFFF;
	localparam logic [CountW-1:0] GROUP_PIXELS = 21'd8;

endpackage

`default_nettype wire

[hw/rtl/rle_mono_bitmap_expander_core.sv]
// Run-length coded 1-bit bitmap expander to RGB565 pixel groups.
// Takes one item per clock unless stalled: a start, a compressed byte or a fetch. Every
// accepted item gives exactly one result, held in an output register and shown in the cycle
// after acceptance; a new item is taken in the same cycle that the waiting result leaves, so
// with out_stall low the sustained rate is one item per cycle. Depends on rmbe_pkg.
// Next-state logic holds the 10x10 width-by-height product feeding the pixel-count compare.
`default_nettype none

module rle_mono_bitmap_expander_core (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// configuration write port
	input  wire logic                           cfg_wr_en,
	input  wire logic [rmbe_pkg::CfgIdxW-1:0]   cfg_index,
	input  wire logic [rmbe_pkg::ColorW-1:0]    cfg_data,
	// input channel
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [rmbe_pkg::ReqW-1:0]      req_type,
	input  wire logic [rmbe_pkg::ByteW-1:0]     data_byte,
	// output channel
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic                                group_valid,
	output logic [rmbe_pkg::GroupW-1:0]         pixels_first,
	output logic [rmbe_pkg::GroupW-1:0]         pixels_second,
	output logic                                want_byte,
	output logic                                done_res,
	output logic                                byte_dropped
);
	import rmbe_pkg::*;

	// configuration registers
	logic [ColorW-1:0] fg_q;
	logic [ColorW-1:0] bg_q;
	logic [DimW-1:0]   width_q;
	logic [DimW-1:0]   height_q;

	// decoder state
	logic [PhaseW-1:0] phase_q, phase_d;
	logic [ByteW-1:0]  pattern_q, pattern_d;
	logic [ByteW-1:0]  groups_q, groups_d;
	logic [CountW-1:0] count_q, count_d;

	// result register
	logic              out_valid_q;
	logic              group_valid_q, group_valid_d;
	logic [GroupW-1:0] first_q, first_d;
	logic [GroupW-1:0] second_q, second_d;
	logic              want_q, want_d;
	logic              done_q, done_d;
	logic              dropped_q, dropped_d;

	logic              accept;
	logic [TotalW-1:0] total_pixels;
	logic [CountW-1:0] total_ext;
	logic              done_now;
	logic              done_next;

	// one-deep output register: take a new item whenever the result slot frees up
	assign in_stall = out_valid_q & out_stall;
	assign accept   = in_valid & ~in_stall;

	// pixel total read live from the registers
	assign total_pixels = TotalW'(width_q) * TotalW'(height_q);
	assign total_ext    = {{(CountW - TotalW){1'b0}}, total_pixels};
	assign done_now     = (phase_q == PH_CODE) && (count_q >= total_ext);
	assign done_next    = (phase_d == PH_CODE) && (count_d >= total_ext);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q     <= FG_RESET;
			bg_q     <= '0;
			width_q  <= '0;
			height_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_FG_COLOR: fg_q     <= cfg_data;
				CFG_BG_COLOR: bg_q     <= cfg_data;
				CFG_WIDTH:    width_q  <= cfg_data[DimW-1:0];
				CFG_HEIGHT:   height_q <= cfg_data[DimW-1:0];
				default: begin
				end
			endcase
		end
	end

	// item decode and next state
	always_comb begin
		phase_d       = phase_q;
		pattern_d     = pattern_q;
		groups_d      = groups_q;
		count_d       = count_q;
		group_valid_d = 1'b0;
		first_d       = '0;
		second_d      = '0;
		dropped_d     = 1'b0;
		case (req_type)
			REQ_START: begin
				phase_d   = PH_CODE;
				pattern_d = '0;
				groups_d  = '0;
				count_d   = '0;
			end
			REQ_BYTE: begin
				if ((groups_q != '0) || done_now) begin
					dropped_d = 1'b1;
				end else begin
					case (phase_q)
						PH_CODE: begin
							if (data_byte == ESC_CODE) begin
								phase_d = PH_PATTERN;
							end else begin
								pattern_d = data_byte;
								groups_d  = 8'd1;
								count_d   = count_q + GROUP_PIXELS;
							end
						end
						PH_PATTERN: begin
							pattern_d = data_byte;
							phase_d   = PH_COUNT;
						end
						default: begin
							// repeat count closes the escape
							groups_d = data_byte;
							count_d  = count_q + {{(CountW - ByteW - 3){1'b0}}, data_byte, 3'b000};
							phase_d  = PH_CODE;
						end
					endcase
				end
			end
			REQ_FETCH: begin
				if (groups_q != '0) begin
					group_valid_d = 1'b1;
					groups_d      = groups_q - 8'd1;
					// msb of the pattern is pixel 0
					for (int i = 0; i < LaneN; i++) begin
						first_d[ColorW*i +: ColorW]  =
							pattern_q[ByteW-1-i] ? fg_q : bg_q;
						second_d[ColorW*i +: ColorW] =
							pattern_q[ByteW-1-LaneN-i] ? fg_q : bg_q;
					end
				end
			end
			default: begin
			end
		endcase
		want_d = (groups_d == '0) && !done_next;
		done_d = (groups_d == '0) && done_next;
	end

	// decoder state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_CODE;
			pattern_q <= '0;
			groups_q  <= '0;
			count_q   <= '0;
		end else if (accept) begin
			phase_q   <= phase_d;
			pattern_q <= pattern_d;
			groups_q  <= groups_d;
			count_q   <= count_d;
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			group_valid_q <= group_valid_d;
			first_q       <= first_d;
			second_q      <= second_d;
			want_q        <= want_d;
			done_q        <= done_d;
			dropped_q     <= dropped_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign group_valid   = group_valid_q;
	assign pixels_first  = first_q;
	assign pixels_second = second_q;
	assign want_byte     = want_q;
	assign done_res      = done_q;
	assign byte_dropped  = dropped_q;

endmodule

`default_nettype wire

[hw/rtl/rmbe_checker.sv]
// port-level checks for the run-length bitmap expander, bound to the top level
// depends on rmbe_pkg and rle_mono_bitmap_expander_core_assert.svh
`default_nettype none

`include "rle_mono_bitmap_expander_core_assert.svh"

module rmbe_checker (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	input  wire logic                           in_stall,
	input  wire logic [rmbe_pkg::ReqW-1:0]      req_type,
	input  wire logic                           out_valid,
	input  wire logic                           out_stall,
	input  wire logic                           group_valid,
	input  wire logic [rmbe_pkg::GroupW-1:0]    pixels_first,
	input  wire logic [rmbe_pkg::GroupW-1:0]    pixels_second,
	input  wire logic                           want_byte,
	input  wire logic                           done_res,
	input  wire logic                           byte_dropped
);
	import rmbe_pkg::*;

	logic in_acc;

	assign in_acc = in_valid && !in_stall;

	// a start item never reports a group or a dropped byte
	property p_start_result;
		in_acc && (req_type == REQ_START) |=> !group_valid && !byte_dropped;
	endproperty

	// a result without a group carries no pixels
	property p_empty_pixels;
		out_valid && !group_valid |-> (pixels_first == '0) && (pixels_second == '0);
	endproperty

	// a stalled result holds
	property p_stall_hold;
		out_valid && out_stall |=> out_valid && $stable(group_valid)
			&& $stable(pixels_first) && $stable(pixels_second);
	endproperty

	// every accepted item leaves a result in the output register
	`RMBE_ASSERT(a_accept_gives_result, in_acc |=> out_valid, "accepted item gave no result")

	`RMBE_ASSERT(a_start_result, p_start_result, "start item reported a group or a drop")

	// status flags are exclusive
	`RMBE_ASSERT(a_status_excl, out_valid |-> !(want_byte && done_res), "status flags both set")

	`RMBE_ASSERT(a_empty_pixels, p_empty_pixels, "pixels set without a group")

	`RMBE_ASSERT(a_stall_hold, p_stall_hold, "stalled result changed")

endmodule

bind rle_mono_bitmap_expander_core rmbe_checker u_rmbe_checker (.*);

`default_nettype wire
